// ===== sv/bcs_pkg.sv =====
// Package for the battery charge supervisor: widths, constants, register indexes
// and the struct types shared by the lanes, the merge stage and the top level.
// No dependencies.
package bcs_pkg;

    // Sample width of the converters
    localparam int ADC_BITS = 10;

    // Q8.16 value width and scale width
    localparam int Q_W     = 24;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = ADC_BITS + SCALE_W;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 20;

    // Filter gain 655 / 2^16, product width of the gain multiply
    localparam int GAIN_W = 10;
    localparam logic [GAIN_W-1:0] FILTER_GAIN = GAIN_W'(655);
    localparam int MUL_W  = Q_W + GAIN_W;

    localparam logic [Q_W-1:0] Q_MAX         = {Q_W{1'b1}};
    localparam logic [Q_W-1:0] VOLT_JUMP     = Q_W'(327680);
    localparam logic [Q_W-1:0] AMP_JUMP      = Q_W'(32768);
    localparam logic [Q_W-1:0] STATION_LEVEL = Q_W'(655360);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGER_VOLT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_OFF_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHARGE_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_CURRENT_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS         = 3'd6;

    // Register reset values
    localparam logic [SCALE_W-1:0] RST_BATTERY_SCALE      = SCALE_W'(5125);
    localparam logic [SCALE_W-1:0] RST_CHARGER_VOLT_SCALE = SCALE_W'(5125);
    localparam logic [SCALE_W-1:0] RST_CURRENT_SCALE      = SCALE_W'(320);
    localparam logic [Q_W-1:0]     RST_SWITCH_OFF_LEVEL   = Q_W'(1376256);
    localparam logic [Q_W-1:0]     RST_START_CHARGE_LEVEL = Q_W'(1638400);
    localparam logic [Q_W-1:0]     RST_FULL_CURRENT_LEVEL = Q_W'(6554);
    localparam logic [HOLD_W-1:0]  RST_HOLDOFF_MS         = HOLD_W'(30000);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIFF,
        ST_MUL,
        ST_FILT,
        ST_DECIDE
    } state_t;

    // Request payloads
    typedef struct packed {
        logic [ADC_BITS-1:0] battery_sample;
        logic [ADC_BITS-1:0] charger_sample;
        logic [ADC_BITS-1:0] current_sample;
        logic [TIME_W-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        logic [Q_W-1:0] battery_volts;
        logic [Q_W-1:0] charger_volts;
        logic [Q_W-1:0] charge_amps;
        logic           in_station;
        logic           charging;
        logic           charge_enable;
        logic           battery_off;
    } out_item_t;

    // Step strobes from the sequencer to every lane
    typedef struct packed {
        logic scale_en;
        logic diff_en;
        logic mul_en;
        logic filt_en;
    } lane_ctrl_t;

    // Levels used by the merge stage
    typedef struct packed {
        logic [Q_W-1:0]    switch_off_level;
        logic [Q_W-1:0]    start_charge_level;
        logic [Q_W-1:0]    full_current_level;
        logic [HOLD_W-1:0] holdoff_ms;
    } level_cfg_t;

    // Supervisor flags
    typedef struct packed {
        logic in_station;
        logic charging;
        logic charge_enable;
        logic battery_off;
    } status_t;

endpackage

// ===== sv/bcs_lane.sv =====
// One filter lane: scales a raw sample to Q8.16 with saturation and runs the
// jump-or-low-pass filter update over four steps. Depends on bcs_pkg.
module bcs_lane (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bcs_pkg::lane_ctrl_t          ctrl,
    input  logic [bcs_pkg::ADC_BITS-1:0] sample,
    input  logic [bcs_pkg::SCALE_W-1:0]  scale,
    input  logic [bcs_pkg::Q_W-1:0]      jump,
    output logic [bcs_pkg::Q_W-1:0]      filt_value
);

    logic [bcs_pkg::PROD_W-1:0] prod_reg;
    logic [bcs_pkg::Q_W-1:0]    x_reg;
    logic [bcs_pkg::Q_W-1:0]    d_reg;
    logic                       up_reg;
    logic                       jump_reg;
    logic [bcs_pkg::MUL_W-1:0]  m_reg;
    logic [bcs_pkg::Q_W-1:0]    filt_reg;
    logic [bcs_pkg::Q_W-1:0]    filt_next;

    logic [bcs_pkg::Q_W-1:0]    x_sat;
    logic                       up;
    logic [bcs_pkg::Q_W-1:0]    d;
    logic [bcs_pkg::MUL_W:0]    m_round;

    // Saturate the scaled sample and take the distance to the filter value
    always_comb begin
        if (prod_reg > bcs_pkg::PROD_W'(bcs_pkg::Q_MAX)) begin
            x_sat = bcs_pkg::Q_MAX;
        end else begin
            x_sat = prod_reg[bcs_pkg::Q_W-1:0];
        end
        up = (x_sat >= filt_reg);
        d  = up ? (x_sat - filt_reg) : (filt_reg - x_sat);
    end

    // Step down rounds the shifted gain product up, step up rounds it down
    always_comb begin
        m_round = {1'b0, m_reg} + (bcs_pkg::MUL_W + 1)'(16'hFFFF);
        if (jump_reg) begin
            filt_next = x_reg;
        end else if (up_reg) begin
            filt_next = filt_reg + bcs_pkg::Q_W'(m_reg[bcs_pkg::MUL_W-1:16]);
        end else begin
            filt_next = filt_reg - bcs_pkg::Q_W'(m_round[bcs_pkg::MUL_W:16]);
        end
    end

    // Datapath steps: scale, difference, gain multiply
    always_ff @(posedge aclk) begin
        if (ctrl.scale_en) begin
            prod_reg <= bcs_pkg::PROD_W'(sample) * bcs_pkg::PROD_W'(scale);
        end
        if (ctrl.diff_en) begin
            x_reg    <= x_sat;
            d_reg    <= d;
            up_reg   <= up;
            jump_reg <= (d > jump);
        end
        if (ctrl.mul_en) begin
            m_reg <= bcs_pkg::MUL_W'(d_reg) * bcs_pkg::MUL_W'(bcs_pkg::FILTER_GAIN);
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (ctrl.filt_en) begin
            filt_reg <= filt_next;
        end
    end

    assign filt_value = filt_reg;

endmodule

// ===== sv/bcs_merge.sv =====
// Merge stage: combines the three filtered lanes into the station, charge
// and switch-off decisions and holds the supervisor flags. Depends on bcs_pkg.
module bcs_merge (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       decide_en,
    input  bcs_pkg::level_cfg_t        levels,
    input  logic [bcs_pkg::Q_W-1:0]    battery_volts,
    input  logic [bcs_pkg::Q_W-1:0]    charger_volts,
    input  logic [bcs_pkg::Q_W-1:0]    charge_amps,
    input  logic [bcs_pkg::TIME_W-1:0] now_ms,
    output bcs_pkg::status_t           status_next,
    output bcs_pkg::status_t           status_now
);

    bcs_pkg::status_t            status_reg;
    logic [bcs_pkg::TIME_W-1:0]  last_toggle_reg;
    logic [bcs_pkg::TIME_W-1:0]  last_toggle_next;
    logic [bcs_pkg::TIME_W-1:0]  elapsed;
    logic                        holdoff_done;
    logic                        charging_kept;

    // Decide switch-off, station and charge start or stop
    always_comb begin
        elapsed      = now_ms - last_toggle_reg;
        holdoff_done = (elapsed > bcs_pkg::TIME_W'(levels.holdoff_ms));

        status_next.battery_off   = status_reg.battery_off |
                                    (battery_volts <= levels.switch_off_level);
        status_next.in_station    = (charger_volts > bcs_pkg::STATION_LEVEL);
        charging_kept             = status_reg.charging & status_next.in_station;
        status_next.charging      = charging_kept;
        status_next.charge_enable = status_reg.charge_enable;
        last_toggle_next          = last_toggle_reg;

        if (!charging_kept) begin
            if ((battery_volts < levels.start_charge_level) && holdoff_done) begin
                status_next.charging      = 1'b1;
                status_next.charge_enable = 1'b1;
                last_toggle_next          = now_ms;
            end
        end else begin
            if ((charge_amps <= levels.full_current_level) && holdoff_done) begin
                status_next.charging      = 1'b0;
                status_next.charge_enable = 1'b0;
            end
        end
    end

    // Hold the flags and the last start time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= '0;
            last_toggle_reg <= '0;
        end else if (decide_en) begin
            status_reg      <= status_next;
            last_toggle_reg <= last_toggle_next;
        end
    end

    assign status_now = status_reg;

endmodule

// ===== sv/battery_charge_supervisor_top.sv =====
// Battery charge supervisor top level: configuration registers, step
// sequencer, three filter lanes, merge stage and the result register.
// Depends on bcs_pkg, bcs_lane and bcs_merge.
// A request is accepted only in the idle state, so a new request waits until
// the previous one has passed the four lane steps and the merge step of the
// shared sequencer; a waiting result stalls the merge step and so also the
// next accept.
// Reset (aresetn low, synchronous): filters, flags and last start time clear,
// registers take their defaults, no result is pending.
module battery_charge_supervisor_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bcs_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bcs_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [bcs_pkg::SCALE_W-1:0] battery_scale_reg;
    logic [bcs_pkg::SCALE_W-1:0] charger_volt_scale_reg;
    logic [bcs_pkg::SCALE_W-1:0] current_scale_reg;
    bcs_pkg::level_cfg_t         levels_reg;

    bcs_pkg::state_t     state_reg;
    bcs_pkg::state_t     state_next;
    bcs_pkg::in_item_t   item_reg;
    bcs_pkg::out_item_t  out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_load;
    logic                decide_en;
    bcs_pkg::lane_ctrl_t lane_ctrl;

    logic [bcs_pkg::Q_W-1:0] battery_filt;
    logic [bcs_pkg::Q_W-1:0] charger_filt;
    logic [bcs_pkg::Q_W-1:0] current_filt;
    bcs_pkg::status_t        status_next;
    bcs_pkg::status_t        status_now;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            battery_scale_reg             <= bcs_pkg::RST_BATTERY_SCALE;
            charger_volt_scale_reg        <= bcs_pkg::RST_CHARGER_VOLT_SCALE;
            current_scale_reg             <= bcs_pkg::RST_CURRENT_SCALE;
            levels_reg.switch_off_level   <= bcs_pkg::RST_SWITCH_OFF_LEVEL;
            levels_reg.start_charge_level <= bcs_pkg::RST_START_CHARGE_LEVEL;
            levels_reg.full_current_level <= bcs_pkg::RST_FULL_CURRENT_LEVEL;
            levels_reg.holdoff_ms         <= bcs_pkg::RST_HOLDOFF_MS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bcs_pkg::REG_BATTERY_SCALE: begin
                    battery_scale_reg <= cfg_wdata[bcs_pkg::SCALE_W-1:0];
                end
                bcs_pkg::REG_CHARGER_VOLT_SCALE: begin
                    charger_volt_scale_reg <= cfg_wdata[bcs_pkg::SCALE_W-1:0];
                end
                bcs_pkg::REG_CURRENT_SCALE: begin
                    current_scale_reg <= cfg_wdata[bcs_pkg::SCALE_W-1:0];
                end
                bcs_pkg::REG_SWITCH_OFF_LEVEL: begin
                    levels_reg.switch_off_level <= cfg_wdata[bcs_pkg::Q_W-1:0];
                end
                bcs_pkg::REG_START_CHARGE_LEVEL: begin
                    levels_reg.start_charge_level <= cfg_wdata[bcs_pkg::Q_W-1:0];
                end
                bcs_pkg::REG_FULL_CURRENT_LEVEL: begin
                    levels_reg.full_current_level <= cfg_wdata[bcs_pkg::Q_W-1:0];
                end
                bcs_pkg::REG_HOLDOFF_MS: begin
                    levels_reg.holdoff_ms <= cfg_wdata[bcs_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // State register and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence the lane steps, then merge once the result register is free
    always_comb begin
        state_next     = state_reg;
        lane_ctrl      = '0;
        decide_en      = 1'b0;
        out_load       = 1'b0;
        s_ready        = 1'b0;
        out_valid_next = out_valid_reg & ~m_ready;
        case (state_reg)
            bcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = bcs_pkg::ST_SCALE;
                end
            end
            bcs_pkg::ST_SCALE: begin
                lane_ctrl.scale_en = 1'b1;
                state_next         = bcs_pkg::ST_DIFF;
            end
            bcs_pkg::ST_DIFF: begin
                lane_ctrl.diff_en = 1'b1;
                state_next        = bcs_pkg::ST_MUL;
            end
            bcs_pkg::ST_MUL: begin
                lane_ctrl.mul_en = 1'b1;
                state_next       = bcs_pkg::ST_FILT;
            end
            bcs_pkg::ST_FILT: begin
                lane_ctrl.filt_en = 1'b1;
                state_next        = bcs_pkg::ST_DECIDE;
            end
            bcs_pkg::ST_DECIDE: begin
                if (!out_valid_reg || m_ready) begin
                    decide_en      = 1'b1;
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Capture the request, load the result
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            out_reg.battery_volts <= battery_filt;
            out_reg.charger_volts <= charger_filt;
            out_reg.charge_amps   <= current_filt;
            out_reg.in_station    <= status_next.in_station;
            out_reg.charging      <= status_next.charging;
            out_reg.charge_enable <= status_next.charge_enable;
            out_reg.battery_off   <= status_next.battery_off;
        end
    end

    bcs_lane u_battery_lane (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .sample     (item_reg.battery_sample),
        .scale      (battery_scale_reg),
        .jump       (bcs_pkg::VOLT_JUMP),
        .filt_value (battery_filt)
    );

    bcs_lane u_charger_lane (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .sample     (item_reg.charger_sample),
        .scale      (charger_volt_scale_reg),
        .jump       (bcs_pkg::VOLT_JUMP),
        .filt_value (charger_filt)
    );

    bcs_lane u_current_lane (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .sample     (item_reg.current_sample),
        .scale      (current_scale_reg),
        .jump       (bcs_pkg::AMP_JUMP),
        .filt_value (current_filt)
    );

    bcs_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .decide_en     (decide_en),
        .levels        (levels_reg),
        .battery_volts (battery_filt),
        .charger_volts (charger_filt),
        .charge_amps   (current_filt),
        .now_ms        (item_reg.now_ms),
        .status_next   (status_next),
        .status_now    (status_now)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Switch-off latch never releases outside reset
    a_off_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(status_now.battery_off))
        else $error("battery switch-off released");

    // Charging is only ever flagged with the enable pin driven
    a_charge_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.charging || m_data.charge_enable))
        else $error("charging flagged with enable pin low");

    // A held result stalls the merge step
    a_merge_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bcs_pkg::ST_DECIDE && m_valid && !m_ready)
        |=> (state_reg == bcs_pkg::ST_DECIDE && m_valid))
        else $error("result overwritten while held");

endmodule
